@@ design/path_mtu_route_cache_unit_defines.svh @@
// Assertion macros shared by the path MTU route cache RTL.
`ifndef PATH_MTU_ROUTE_CACHE_UNIT_DEFINES_SVH
`define PATH_MTU_ROUTE_CACHE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define PMRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define PMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pmrc_pkg.sv @@
// Types, constants and helpers of the path MTU route cache.
package pmrc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned MTU_W  = 17;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CFG_W  = 17;

  localparam logic [MTU_W-1:0] LIMIT_FALLBACK = 17'd1500;
  localparam logic [MTU_W-1:0] INITIAL_RESET  = 17'd1500;
  localparam logic [MTU_W-1:0] FLOOR_RESET    = 17'd68;

  // Configuration register indexes
  localparam logic [1:0] CFG_DECLARED = 2'd0;
  localparam logic [1:0] CFG_INITIAL  = 2'd1;
  localparam logic [1:0] CFG_FLOOR    = 2'd2;

  // Item kinds
  localparam logic KIND_QUERY   = 1'b0;
  localparam logic KIND_TOO_BIG = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [MTU_W-1:0]  mtu;
  } entry_t;

  typedef struct packed {
    logic             lowered;
    logic             stored;
    logic             hit;
    logic [MTU_W-1:0] limit;
  } result_t;

  // Cap a route answer by the global limit when the limit was declared
  function automatic logic [MTU_W-1:0] blend_limit(logic declared,
                                                   logic [MTU_W-1:0] route,
                                                   logic [MTU_W-1:0] cap);
    logic [MTU_W-1:0] r;
    r = route;
    if (declared && (cap < route)) begin
      r = cap;
    end
    return r;
  endfunction

endpackage

@@ design/path_mtu_route_cache_unit.sv @@
// Path MTU route cache: ring of destination/MTU entries with a global limit.
//
// Usage:
//   s_axis carries one item per beat: tuser is the kind (query or too-big),
//   tdata the destination, probe answer and rejected length. m_axis returns
//   one result beat per item: limit, hit, stored and lowered flags.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the three configuration registers;
//   write them only while no item is in flight.
//   The block handles one item at a time. A query, or a too-big event above
//   the floor, scans every entry through the registered read port of the
//   entry memory, one entry a cycle, and stops at the first match. The input
//   is ready again in the cycle that the result becomes valid. The result sits
//   in an output register; the next item is taken while it waits. If the
//   receiver stalls and the register is still full when the following item
//   finishes, that item holds before any state update until the register
//   frees, and no further item is accepted.
//   Reset clears the entry valid bits, the ring pointer, the lowered limit and
//   the registers (declared 0, initial 1500, floor 68); no memory sweep.
module path_mtu_route_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  // item input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // dst_addr[31:0], probed_mtu[48:32],
                                      // packet_length[64:49], zero pad
  input  logic        s_axis_tuser,   // kind
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // limit[16:0], hit[17], stored[18],
                                      // lowered[19], zero pad
);

  `include "path_mtu_route_cache_unit_defines.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int unsigned IW = pmrc_pkg::IDX_W;
  localparam int unsigned MW = pmrc_pkg::MTU_W;

  // configuration
  logic          declared_q;
  logic [MW-1:0] initial_q;
  logic [MW-1:0] floor_q;

  // control
  logic [1:0]    state_q, state_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [MW-1:0] lowered_q, lowered_d;
  logic [pmrc_pkg::ENTRIES-1:0] vld_q, vld_d;

  // latched item
  logic                        kind_q;
  logic [pmrc_pkg::ADDR_W-1:0] addr_q;
  logic [MW-1:0]               probe_q;
  logic [pmrc_pkg::LEN_W-1:0]  len_q;

  // scan
  logic [IW-1:0] rd_idx_q, rd_idx_d;
  logic          rd_more_q, rd_more_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          found_q, found_d;
  logic [IW-1:0] slot_q, slot_d;
  logic [MW-1:0] slot_mtu_q, slot_mtu_d;

  // memory
  pmrc_pkg::entry_t mem [pmrc_pkg::ENTRIES];
  pmrc_pkg::entry_t rd_data_q;
  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  pmrc_pkg::entry_t mem_wdata;

  // output register
  logic              out_valid_q, out_valid_d;
  pmrc_pkg::result_t out_q;
  pmrc_pkg::result_t res;
  logic              out_load;

  logic          in_fire;
  logic          cmp_match;
  logic          len_above;
  logic [MW-1:0] cur_limit, cap_limit, low_len;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

  assign cur_limit = (lowered_q != '0) ? lowered_q : initial_q;
  assign cap_limit = (cur_limit != '0) ? cur_limit : pmrc_pkg::LIMIT_FALLBACK;
  assign low_len   = MW'(len_q) - MW'(1);
  assign len_above = MW'(len_q) > floor_q;

  assign cmp_match = cmp_vld_q && vld_q[cmp_idx_q] && (rd_data_q.mtu != '0) &&
                     (rd_data_q.addr == addr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      declared_q <= 1'b0;
      initial_q  <= pmrc_pkg::INITIAL_RESET;
      floor_q    <= pmrc_pkg::FLOOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pmrc_pkg::CFG_DECLARED: declared_q <= cfg_wdata_i[0];
        pmrc_pkg::CFG_INITIAL:  initial_q  <= cfg_wdata_i;
        pmrc_pkg::CFG_FLOOR:    floor_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    lowered_d   = lowered_q;
    vld_d       = vld_q;
    rd_idx_d    = rd_idx_q;
    rd_more_d   = rd_more_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    slot_mtu_d  = slot_mtu_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = '{addr: addr_q, mtu: probe_q};
    res         = '{lowered: 1'b0, stored: 1'b0, hit: 1'b0, limit: cap_limit};
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          found_d   = 1'b0;
          rd_idx_d  = '0;
          rd_more_d = 1'b1;
          if ((s_axis_tuser == pmrc_pkg::KIND_TOO_BIG) &&
              (MW'(s_axis_tdata[64:49]) <= floor_q)) begin
            state_d = S_FIN;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp_match) begin
          found_d    = 1'b1;
          slot_d     = cmp_idx_q;
          slot_mtu_d = rd_data_q.mtu;
          state_d    = S_FIN;
        end else if (cmp_vld_q && (cmp_idx_q == pmrc_pkg::LAST_IDX)) begin
          state_d = S_FIN;
        end else if (rd_more_q) begin
          // issue the next entry read; its data is compared next cycle
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q;
          if (rd_idx_q == pmrc_pkg::LAST_IDX) begin
            rd_more_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + IW'(1);
          end
        end
      end
      S_FIN: begin
        // hold every update until the output register can take the result
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (kind_q == pmrc_pkg::KIND_QUERY) begin
            if (found_q) begin
              res.hit   = 1'b1;
              res.limit = pmrc_pkg::blend_limit(declared_q, slot_mtu_q, cap_limit);
            end else if (probe_q >= floor_q) begin
              mem_we     = 1'b1;
              vld_d[ptr_q] = 1'b1;
              ptr_d      = (ptr_q == pmrc_pkg::LAST_IDX) ? '0 : ptr_q + IW'(1);
              res.stored = 1'b1;
              res.limit  = pmrc_pkg::blend_limit(declared_q, probe_q, cap_limit);
            end
          end else if (len_above) begin
            if (found_q) begin
              res.hit = 1'b1;
              if (low_len < slot_mtu_q) begin
                mem_we    = 1'b1;
                mem_waddr = slot_q;
                mem_wdata = '{addr: addr_q, mtu: low_len};
              end
            end
            if ((low_len != '0) && (low_len < cur_limit)) begin
              lowered_d   = low_len;
              res.lowered = 1'b1;
              res.limit   = low_len;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      lowered_q   <= '0;
      vld_q       <= '0;
      rd_more_q   <= 1'b0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      lowered_q   <= lowered_d;
      vld_q       <= vld_d;
      rd_more_q   <= rd_more_d;
      cmp_vld_q   <= cmp_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    slot_mtu_q <= slot_mtu_d;
    if (in_fire) begin
      kind_q  <= s_axis_tuser;
      addr_q  <= s_axis_tdata[31:0];
      probe_q <= s_axis_tdata[48:32];
      len_q   <= s_axis_tdata[64:49];
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_idx_q];
  end

  `PMRC_ASSERT_NEXT(a_accept_starts_work, in_fire,
                    (state_q == S_SCAN) || (state_q == S_FIN),
                    "accepted item did not start a scan or finish")
  `PMRC_ASSERT_NOW(a_write_only_at_finish, mem_we,
                   (state_q == S_FIN) && out_load,
                   "entry memory written outside the finishing step")
  `PMRC_ASSERT_NOW(a_load_only_when_free, out_load,
                   !out_valid_q || m_axis_tready,
                   "result loaded over an untaken result")
  `PMRC_ASSERT_NOW(a_ptr_in_range, 1'b1, ptr_q <= pmrc_pkg::LAST_IDX,
                   "ring pointer beyond the last entry")

endmodule

@@ sim/tb.sv @@
// Self-checking bench of the path MTU route cache: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 305;
  localparam int unsigned RANDOM_ITEMS = PHASES * PHASE_ITEMS;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned ENTRIES      = pmrc_pkg::ENTRIES;
  localparam int unsigned IDX_W        = pmrc_pkg::IDX_W;
  localparam int unsigned ADDR_W       = pmrc_pkg::ADDR_W;
  localparam int unsigned MTU_W        = pmrc_pkg::MTU_W;
  localparam int unsigned LEN_W        = pmrc_pkg::LEN_W;
  localparam int unsigned CFG_W        = pmrc_pkg::CFG_W;
  // index past the register list, written to show it is ignored
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;

  typedef struct {
    bit                is_cfg;
    logic [1:0]        idx;
    logic [CFG_W-1:0]  wdata;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [MTU_W-1:0]  probe;
    logic [LEN_W-1:0]  len;
    bit                typed;
    pmrc_pkg::result_t answer;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [1:0]        cfg_idx_i     = '0;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [71:0]       s_axis_tdata  = '0;  // dst_addr, probed_mtu, packet_length, zero pad
  logic              s_axis_tuser  = 1'b0; // kind
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;         // limit, hit, stored, lowered, zero pad

  path_mtu_route_cache_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the cache and its registers
  logic [ADDR_W-1:0] cache_addr [ENTRIES];
  logic [MTU_W-1:0]  cache_mtu  [ENTRIES];
  logic [IDX_W-1:0]  ring_ptr;
  logic [MTU_W-1:0]  lowered_lim;
  logic              cfg_declared;
  logic [MTU_W-1:0]  cfg_initial;
  logic [MTU_W-1:0]  cfg_floor;

  pmrc_pkg::result_t route_answer_q [$];
  pmrc_pkg::result_t answer_want;
  int unsigned src_idle_pct  = 6;
  int unsigned sink_idle_pct = 52;
  int unsigned err_cnt = 0;
  int unsigned n_items = 0;
  int unsigned n_hits = 0;
  int unsigned n_stores = 0;
  int unsigned n_lowers = 0;
  int unsigned n_settings = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [MTU_W-1:0] global_cap();
    logic [MTU_W-1:0] g;
    g = (lowered_lim != '0) ? lowered_lim : cfg_initial;
    return (g != '0) ? g : pmrc_pkg::LIMIT_FALLBACK;
  endfunction

  function automatic logic [MTU_W-1:0] cap_route(logic [MTU_W-1:0] route,
                                                 logic [MTU_W-1:0] cap);
    return (cfg_declared && (cap < route)) ? cap : route;
  endfunction

  function automatic pmrc_pkg::result_t predict_route_answer(logic kind,
                                                             logic [ADDR_W-1:0] addr,
                                                             logic [MTU_W-1:0] probe,
                                                             logic [LEN_W-1:0] len);
    pmrc_pkg::result_t r;
    int                slot;
    logic [MTU_W-1:0]  cap;
    logic [MTU_W-1:0]  low;
    logic [MTU_W-1:0]  cur;
    r    = '0;
    cap  = global_cap();
    slot = -1;
    // first valid entry wins; empty entries are never compared
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (cache_mtu[i] != '0 && cache_addr[i] == addr) slot = i;
    end
    if (kind == pmrc_pkg::KIND_QUERY) begin
      if (slot >= 0) begin
        r.hit   = 1'b1;
        r.limit = cap_route(cache_mtu[slot], cap);
      end else if (probe < cfg_floor) begin
        r.limit = cap;
      end else begin
        cache_addr[ring_ptr] = addr;
        cache_mtu[ring_ptr]  = probe;
        ring_ptr             = ring_ptr + IDX_W'(1);
        r.stored             = 1'b1;
        r.limit              = cap_route(probe, cap);
      end
    end else begin
      if (MTU_W'(len) > cfg_floor) begin
        low = MTU_W'(len) - MTU_W'(1);
        cur = (lowered_lim != '0) ? lowered_lim : cfg_initial;
        if (slot >= 0) begin
          r.hit = 1'b1;
          if (low < cache_mtu[slot]) cache_mtu[slot] = low;
        end
        // zero would select the initial limit again, so never store it
        if (low != '0 && low < cur) begin
          lowered_lim = low;
          r.lowered   = 1'b1;
        end
      end
      r.limit = global_cap();
    end
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [CFG_W-1:0] wdata);
    stim_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.wdata  = wdata;
    return row;
  endfunction

  function automatic stim_row_t item_row(logic kind, logic [ADDR_W-1:0] addr,
                                         logic [MTU_W-1:0] probe, logic [LEN_W-1:0] len,
                                         bit typed, logic [MTU_W-1:0] limit,
                                         logic hit, logic stored, logic lowered);
    stim_row_t row;
    row                = '{default: '0};
    row.kind           = kind;
    row.addr           = addr;
    row.probe          = probe;
    row.len            = len;
    row.typed          = typed;
    row.answer.limit   = limit;
    row.answer.hit     = hit;
    row.answer.stored  = stored;
    row.answer.lowered = lowered;
    return row;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    unique case (idx)
      pmrc_pkg::CFG_DECLARED: cfg_declared = wdata[0];
      pmrc_pkg::CFG_INITIAL:  cfg_initial  = wdata;
      pmrc_pkg::CFG_FLOOR:    cfg_floor    = wdata;
      default: ;
    endcase
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one beat, hold it until taken, then queue its answer
  task automatic send_item(logic kind, logic [ADDR_W-1:0] addr, logic [MTU_W-1:0] probe,
                           logic [LEN_W-1:0] len, bit typed,
                           pmrc_pkg::result_t typed_answer);
    int unsigned       gap;
    pmrc_pkg::result_t want;
    gap = 0;
    while (gap < 16 && $urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, len, probe, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_route_answer(kind, addr, probe, len);
    if (typed) want = typed_answer;
    route_answer_q.push_back(want);
    n_items++;
    n_hits   += int'(want.hit);
    n_stores += int'(want.stored);
    n_lowers += int'(want.lowered);
  endtask

  // Drop valid and wait until every answer is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (route_answer_q.size() != 0);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      err_cnt++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (route_answer_q.size() == 0) begin
        err_cnt++;
        $error("result beat with no answer pending: %h", m_axis_tdata);
      end else begin
        answer_want = route_answer_q.pop_front();
        compare_field("limit", answer_want.limit, m_axis_tdata[16:0]);
        compare_field("hit", answer_want.hit, m_axis_tdata[17]);
        compare_field("stored", answer_want.stored, m_axis_tdata[18]);
        compare_field("lowered", answer_want.lowered, m_axis_tdata[19]);
        compare_field("pad", 0, m_axis_tdata[23:20]);
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d answers outstanding", n, route_answer_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    stim_row_t         plan [$];
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic              ph_declared [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    logic [CFG_W-1:0]  ph_initial [PHASES]  = '{17'd68, 17'd65536, 17'd0, 17'd1500,
                                                17'd9000, 17'd65536};
    logic [CFG_W-1:0]  ph_floor [PHASES]    = '{17'd68, 17'd0, 17'd1000, 17'd68,
                                                17'd65536, 17'd576};
    int unsigned       ph_too_big_pct [PHASES] = '{0, 0, 15, 15, 15, 20};
    int unsigned       done_items;
    int unsigned       r;
    int                tmp;
    logic              kind;
    logic [ADDR_W-1:0] addr;
    logic [MTU_W-1:0]  probe;
    logic [MTU_W-1:0]  cur;
    logic [LEN_W-1:0]  len;

    for (int i = 0; i < ENTRIES; i++) cache_mtu[i] = '0;
    ring_ptr     = '0;
    lowered_lim  = '0;
    cfg_declared = 1'b0;
    cfg_initial  = pmrc_pkg::INITIAL_RESET;
    cfg_floor    = pmrc_pkg::FLOOR_RESET;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero initial limit falls back to 1500 and leaves nothing to lower
    plan.push_back(cfg_row(pmrc_pkg::CFG_INITIAL, 17'd0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h0000_0000, 17'd0, 16'd0, 1,
                            17'd1500, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_TOO_BIG, 32'h0000_0000, 17'd0, 16'd1400, 1,
                            17'd1500, 0, 0, 0));
    plan.push_back(cfg_row(pmrc_pkg::CFG_INITIAL, 17'd65536));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'hFFFF_FFFF, 17'd67, 16'd0, 1,
                            17'd65536, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'hFFFF_FFFF, 17'd68, 16'd0, 1,
                            17'd68, 0, 1, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'hFFFF_FFFF, 17'd9000, 16'd0, 1,
                            17'd68, 1, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h0000_0000, 17'd65536, 16'hFFFF, 1,
                            17'd65536, 0, 1, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h0A00_0001, 17'h1FFFF, 16'd0, 0,
                            0, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_TOO_BIG, 32'h0000_0000, 17'd0, 16'd68, 1,
                            17'd65536, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_TOO_BIG, 32'h0000_0000, 17'h1FFFF, 16'd65535, 1,
                            17'd65534, 1, 0, 1));
    plan.push_back(cfg_row(pmrc_pkg::CFG_DECLARED, 17'd1));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h0A00_0001, 17'd0, 16'd0, 0,
                            0, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_TOO_BIG, 32'hFFFF_FFFF, 17'd0, 16'd65535, 0,
                            0, 0, 0, 0));
    // floor zero: a zero probe is stored but leaves the entry empty
    plan.push_back(cfg_row(pmrc_pkg::CFG_FLOOR, 17'd0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h1234_5678, 17'd0, 16'd0, 1,
                            17'd0, 0, 1, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h1234_5678, 17'd0, 16'd0, 0,
                            0, 0, 0, 0));
    // length one empties the matching entry; the global limit ignores a zero
    plan.push_back(item_row(pmrc_pkg::KIND_TOO_BIG, 32'h0A00_0001, 17'd0, 16'd1, 0,
                            0, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h0A00_0001, 17'd3, 16'd0, 0,
                            0, 0, 0, 0));
    plan.push_back(cfg_row(CFG_UNUSED, 17'h1FFFF));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h0000_0000, 17'd7, 16'd0, 0,
                            0, 0, 0, 0));
    plan.push_back(cfg_row(pmrc_pkg::CFG_FLOOR, 17'd65536));
    plan.push_back(item_row(pmrc_pkg::KIND_QUERY, 32'h55AA_55AA, 17'd65535, 16'd0, 1,
                            17'd65534, 0, 0, 0));
    plan.push_back(item_row(pmrc_pkg::KIND_TOO_BIG, 32'h0000_0000, 17'd0, 16'd65535, 1,
                            17'd65534, 0, 0, 0));
    plan.push_back(cfg_row(pmrc_pkg::CFG_FLOOR, 17'd68));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_item(plan[i].kind, plan[i].addr, plan[i].probe, plan[i].len,
                  plan[i].typed, plan[i].answer);
      end
    end
    drain();

    done_items = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(pmrc_pkg::CFG_DECLARED, CFG_W'(ph_declared[ph]));
      write_reg(pmrc_pkg::CFG_INITIAL, ph_initial[ph]);
      write_reg(pmrc_pkg::CFG_FLOOR, ph_floor[ph]);
      if (ph == 3) write_reg(CFG_UNUSED, CFG_W'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        unique case (done_items * 3 / RANDOM_ITEMS)
          0:       begin src_idle_pct = 6;  sink_idle_pct = 52; end
          1:       begin src_idle_pct = 52; sink_idle_pct = 6;  end
          default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
        endcase
        kind = ($urandom_range(0, 99) < ph_too_big_pct[ph]) ? pmrc_pkg::KIND_TOO_BIG
                                                            : pmrc_pkg::KIND_QUERY;
        // reuse a small address pool so hits and ring eviction both happen
        addr = ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : ADDR_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)      probe = '0;
        else if (r < 25) probe = (cfg_floor == '0) ? '0
                                 : MTU_W'($urandom_range(0, cfg_floor - 1));
        else if (r < 35) probe = cfg_floor + MTU_W'($urandom_range(0, 2));
        else if (r < 45) probe = 17'd65536 - MTU_W'($urandom_range(0, 1));
        else if (r < 50) probe = MTU_W'($urandom);
        else             probe = MTU_W'($urandom_range(cfg_floor, 65536));
        cur = (lowered_lim != '0) ? lowered_lim : cfg_initial;
        r   = $urandom_range(0, 99);
        if (r < 15)      tmp = int'($urandom_range(0, cfg_floor));
        else if (r < 50) tmp = int'(cur) + 1 - int'($urandom_range(0, 300));
        else if (r < 80) tmp = int'(cache_mtu[$urandom_range(0, ENTRIES - 1)]) - 1
                               + int'($urandom_range(0, 2));
        else if (r < 85) tmp = (r[0]) ? 65535 : 1;
        else             tmp = int'($urandom_range(0, 65535));
        if (tmp < 0) tmp = 0;
        if (tmp > 65535) tmp = 65535;
        len = LEN_W'(tmp);
        send_item(kind, addr, probe, len, 0, '0);
        done_items++;
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("%0d items over %0d register writes: %0d hits, %0d probes stored, %0d lowerings",
             n_items, n_settings, n_hits, n_stores, n_lowers);
    $display("sender/receiver idling 6/52, 52/6 and none; %0d mismatches", err_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
